// ===== design/mcr_pkg.sv =====
// shared types and constants of the midpoint circle rasterizer
// no dependencies; imported by the channel interfaces and every module but mcr_queue
`default_nettype none
package mcr_pkg;

  localparam int PITCH_W    = 15;
  localparam int SCREEN_W   = 13;
  localparam int OFFSET_W   = 26;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // writes per arc point, and the width of the counter that walks them
  localparam int STEPS_PER_POINT = 8;
  localparam int OCT_W           = $clog2(STEPS_PER_POINT);

  localparam logic [PITCH_W-1:0]  PITCH_RESET  = 15'd4096;
  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } mcr_reg_t;

  typedef struct packed {
    logic [PITCH_W-1:0]  pitch;
    logic [SCREEN_W-1:0] width;
    logic [SCREEN_W-1:0] height;
  } mcr_cfg_t;

endpackage
`default_nettype wire

// ===== design/mcr_in_if.sv =====
// request channel into the rasterizer: start and step items
// depends on mcr_pkg
`default_nettype none
interface mcr_in_if #(parameter int COORD_BITS = 12) ();
  import mcr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-2:0] radius;
  logic [COLOR_W-1:0]    color;

  modport source (output valid, kind, center_x, center_y, radius, color, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, color, output ready);
endinterface
`default_nettype wire

// ===== design/mcr_out_if.sv =====
// pixel write channel out of the rasterizer
// depends on mcr_pkg
`default_nettype none
interface mcr_out_if #(parameter int COORD_BITS = 12) ();
  import mcr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic [OFFSET_W-1:0]          byte_offset;
  logic [COLOR_W-1:0]           pixel_value;
  logic                         in_bounds;
  logic                         last_of_step;
  logic                         circle_done;

  modport source (output valid, pixel_x, pixel_y, byte_offset, pixel_value, in_bounds,
                  last_of_step, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, byte_offset, pixel_value, in_bounds,
                  last_of_step, circle_done, output ready);
endinterface
`default_nettype wire

// ===== design/mcr_cfg_if.sv =====
// register write channel of the rasterizer
// depends on mcr_pkg
`default_nettype none
interface mcr_cfg_if ();
  import mcr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ===== design/mcr_front.sv =====
// front end: takes requests, keeps the arc state, queues one job per drawing step
// depends on mcr_pkg and mcr_in_if
`default_nettype none
module mcr_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  mcr_in_if.sink                                     in_ch,
  output logic                                       push_valid,
  input  wire logic                                  push_ready,
  output logic [4*COORD_BITS+mcr_pkg::COLOR_W:0]     push_data
);
  import mcr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic signed [C-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [C-1:0]         cx_r, cx_nxt, cy_r, cy_nxt;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic                 active_r, active_nxt;

  logic                 accept;
  logic signed [C-1:0]  y_inc, x_step;
  logic signed [EW-1:0] ye, xe, err_step;
  logic                 done_step;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // one midpoint step from the current arc point
  always_comb begin
    y_inc = y_r + C'(1);
    ye    = EW'(y_inc);
    if (err_r[EW-1]) begin
      x_step   = x_r;
      xe       = EW'(x_step);
      err_step = err_r + (ye <<< 1) + EW'(1);
    end else begin
      x_step   = x_r - C'(1);
      xe       = EW'(x_step);
      err_step = err_r + ((ye - xe + EW'(1)) <<< 1);
    end
    done_step = x_step < y_inc;
  end

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    err_nxt    = err_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    active_nxt = active_r;
    push_valid = 1'b0;
    if (accept) begin
      if (in_ch.kind == KIND_START) begin
        cx_nxt     = in_ch.center_x;
        cy_nxt     = in_ch.center_y;
        x_nxt      = C'(in_ch.radius);
        y_nxt      = '0;
        err_nxt    = EW'(1) - EW'(in_ch.radius);
        color_nxt  = in_ch.color;
        active_nxt = 1'b1;
      end else if (active_r) begin
        if (x_r < y_r) begin
          active_nxt = 1'b0;
        end else begin
          push_valid = 1'b1;
          x_nxt      = x_step;
          y_nxt      = y_inc;
          err_nxt    = err_step;
          active_nxt = !done_step;
        end
      end
    end
  end

  assign push_data = {done_step, color_r, cy_r, cx_r, y_r, x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      err_r    <= err_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      active_r <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_final_step_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && done_step) |=> !active_r)
    else $error("circle still active after its final step");
`endif

endmodule
`default_nettype wire

// ===== design/mcr_queue.sv =====
// short job queue between front and back end
// no package dependencies
`default_nettype none
module mcr_queue #(
  parameter int WIDTH = 81,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r < CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count did not grow on push");
`endif

endmodule
`default_nettype wire

// ===== design/mcr_back.sv =====
// back end: walks the eight symmetric writes of a job, bounds check and byte offset
// depends on mcr_pkg and mcr_out_if
`default_nettype none
module mcr_back #(
  parameter int COORD_BITS      = 12,
  parameter int BYTES_PER_PIXEL = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire mcr_pkg::mcr_cfg_t                     cfg,
  input  wire logic                                  pop_valid,
  output logic                                       pop_ready,
  input  wire logic [4*COORD_BITS+mcr_pkg::COLOR_W:0] pop_data,
  mcr_out_if.source                                  out_ch
);
  import mcr_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int EW    = COORD_BITS + 2;
  localparam int JOB_W = 4 * COORD_BITS + COLOR_W + 1;
  localparam int CMPW  = (EW > SCREEN_W) ? EW : SCREEN_W;

  logic [JOB_W-1:0]     job_r, job_nxt;
  logic                 busy_r, busy_nxt;
  logic [OCT_W-1:0]     k_r, k_nxt;

  logic                 s1_v_r, s1_v_nxt;
  logic signed [EW-1:0] s1_px_r, s1_px_nxt, s1_py_r, s1_py_nxt;
  logic                 s1_inb_r, s1_inb_nxt, s1_last_r, s1_last_nxt, s1_done_r, s1_done_nxt;
  logic [COLOR_W-1:0]   s1_color_r, s1_color_nxt;

  logic                 out_v_r, out_v_nxt;
  logic signed [EW-1:0] out_px_r, out_px_nxt, out_py_r, out_py_nxt;
  logic [OFFSET_W-1:0]  out_off_r, out_off_nxt;
  logic [COLOR_W-1:0]   out_color_r, out_color_nxt;
  logic                 out_inb_r, out_inb_nxt, out_last_r, out_last_nxt;
  logic                 out_done_r, out_done_nxt;

  logic                 out_adv, s1_adv, gen, finishing, do_pop, last_k;
  logic signed [EW-1:0] xe, ye, cxe, cye, ga_px, ga_py;
  logic                 ga_inb;
  logic [OFFSET_W-1:0]  off_calc;

  assign out_adv   = !out_v_r || out_ch.ready;
  assign s1_adv    = !s1_v_r || out_adv;
  assign gen       = busy_r && s1_adv;
  assign last_k    = k_r == OCT_W'(STEPS_PER_POINT - 1);
  assign finishing = gen && last_k;
  assign pop_ready = !busy_r || finishing;
  assign do_pop    = pop_valid && pop_ready;

  // job fields: {done, color, cy, cx, y, x}
  always_comb begin
    xe  = EW'($signed(job_r[C-1:0]));
    ye  = EW'($signed(job_r[2*C-1:C]));
    cxe = EW'(job_r[3*C-1:2*C]);
    cye = EW'(job_r[4*C-1:3*C]);
    unique case (k_r)
      3'd0: begin ga_px = cxe + xe; ga_py = cye + ye; end
      3'd1: begin ga_px = cxe + ye; ga_py = cye + xe; end
      3'd2: begin ga_px = cxe - xe; ga_py = cye + ye; end
      3'd3: begin ga_px = cxe - ye; ga_py = cye + xe; end
      3'd4: begin ga_px = cxe - xe; ga_py = cye - ye; end
      3'd5: begin ga_px = cxe - ye; ga_py = cye - xe; end
      3'd6: begin ga_px = cxe + xe; ga_py = cye - ye; end
      3'd7: begin ga_px = cxe + ye; ga_py = cye - xe; end
    endcase
    ga_inb = !ga_px[EW-1] && !ga_py[EW-1] &&
             (CMPW'($unsigned(ga_px)) < CMPW'(cfg.width)) &&
             (CMPW'($unsigned(ga_py)) < CMPW'(cfg.height));
  end

  // row times pitch plus bytes per pixel times column, wrapping
  assign off_calc = OFFSET_W'($unsigned(s1_py_r)) * OFFSET_W'(cfg.pitch) +
                    OFFSET_W'($unsigned(s1_px_r)) * OFFSET_W'(BYTES_PER_PIXEL);

  always_comb begin
    job_nxt  = do_pop ? pop_data : job_r;
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (do_pop) begin
      busy_nxt = 1'b1;
    end else if (finishing) begin
      busy_nxt = 1'b0;
    end
    if (gen) begin
      k_nxt = last_k ? '0 : k_r + OCT_W'(1);
    end

    s1_v_nxt     = s1_v_r;
    s1_px_nxt    = s1_px_r;
    s1_py_nxt    = s1_py_r;
    s1_inb_nxt   = s1_inb_r;
    s1_last_nxt  = s1_last_r;
    s1_done_nxt  = s1_done_r;
    s1_color_nxt = s1_color_r;
    if (s1_adv) begin
      s1_v_nxt     = busy_r;
      s1_px_nxt    = ga_px;
      s1_py_nxt    = ga_py;
      s1_inb_nxt   = ga_inb;
      s1_last_nxt  = last_k;
      s1_done_nxt  = last_k && job_r[JOB_W-1];
      s1_color_nxt = job_r[4*C+COLOR_W-1:4*C];
    end

    out_v_nxt     = out_v_r;
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;
    out_off_nxt   = out_off_r;
    out_color_nxt = out_color_r;
    out_inb_nxt   = out_inb_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (out_adv) begin
      out_v_nxt     = s1_v_r;
      out_px_nxt    = s1_px_r;
      out_py_nxt    = s1_py_r;
      out_off_nxt   = s1_inb_r ? off_calc : '0;
      out_color_nxt = s1_color_r;
      out_inb_nxt   = s1_inb_r;
      out_last_nxt  = s1_last_r;
      out_done_nxt  = s1_done_r;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    s1_px_r     <= s1_px_nxt;
    s1_py_r     <= s1_py_nxt;
    s1_inb_r    <= s1_inb_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_done_r   <= s1_done_nxt;
    s1_color_r  <= s1_color_nxt;
    out_px_r    <= out_px_nxt;
    out_py_r    <= out_py_nxt;
    out_off_r   <= out_off_nxt;
    out_color_r <= out_color_nxt;
    out_inb_r   <= out_inb_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      k_r     <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      k_r     <= k_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.pixel_x      = out_px_r;
  assign out_ch.pixel_y      = out_py_r;
  assign out_ch.byte_offset  = out_off_r;
  assign out_ch.pixel_value  = out_color_r;
  assign out_ch.in_bounds    = out_inb_r;
  assign out_ch.last_of_step = out_last_r;
  assign out_ch.circle_done  = out_done_r;

`ifndef SYNTHESIS
  a_idle_counter_home: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> k_r == '0)
    else $error("write counter not at zero while idle");
  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> busy_r && k_r == '0)
    else $error("popped job did not start at its first write");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_done_r) |-> out_last_r)
    else $error("circle done flagged off the last write of a step");
`endif

endmodule
`default_nettype wire

// ===== design/midpoint_circle_rasterizer.sv =====
// top level of the midpoint circle rasterizer: config registers, front, queue, back
// depends on mcr_pkg, mcr_in_if, mcr_out_if, mcr_cfg_if, mcr_front, mcr_queue, mcr_back
//
// channel   dir  payload                                          request means
// in_ch     in   kind, center_x, center_y, radius, color          start or step a circle
// out_ch    out  pixel_x, pixel_y, byte_offset, pixel_value,      one pixel write
//                in_bounds, last_of_step, circle_done
// cfg_ch    in   reg_index, wr_data                               one register write
//
// a step that draws yields eight writes, one per cycle while out_ch does not stall,
//   paced by the back end's write counter; each write passes stage s1, then the output register
// start requests and steps that draw nothing yield no writes
// sync reset loads pitch 4096, width 1024, height 768 and leaves no circle active
// out_ch stalls freeze the back end; in_ch.ready drops only while the job queue is full
// cfg_ch.ready is always high
`default_nettype none
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS      = 12,
  parameter int BYTES_PER_PIXEL = 4,
  parameter int QUEUE_DEPTH     = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mcr_in_if.sink    in_ch,
  mcr_out_if.source out_ch,
  mcr_cfg_if.sink   cfg_ch
);
  import mcr_pkg::*;

  // job carries one arc point: {done, color, cy, cx, y, x}
  localparam int JOB_W = 4 * COORD_BITS + COLOR_W + 1;

  mcr_cfg_t cfg_r, cfg_nxt;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [JOB_W-1:0] push_data, pop_data;

  // register writes; an index past the list is dropped
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (mcr_reg_t'(cfg_ch.reg_index))
        REG_PITCH:  cfg_nxt.pitch  = cfg_ch.wr_data[PITCH_W-1:0];
        REG_WIDTH:  cfg_nxt.width  = cfg_ch.wr_data[SCREEN_W-1:0];
        REG_HEIGHT: cfg_nxt.height = cfg_ch.wr_data[SCREEN_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pitch  <= PITCH_RESET;
      cfg_r.width  <= WIDTH_RESET;
      cfg_r.height <= HEIGHT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: arc state and midpoint step, one request per cycle while the job queue has room
  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples request intake from the burst of eight writes per job
  mcr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: eight symmetric writes per job, bounds and offset, output register
  mcr_back #(
    .COORD_BITS      (COORD_BITS),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
